[design/sobel_edge_weight_3x3_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel edge-weight block
// Same-cycle and next-cycle implication checks, clocked, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_WEIGHT_3X3_DEFINES_SVH
`define SOBEL_EDGE_WEIGHT_3X3_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SEW_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sew check failed (same-cycle rule)");

// antecedent implies consequent in the next cycle
`define SEW_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sew check failed (next-cycle rule)");

`endif

[design/sew_pkg.sv]
// ----------------------------------------------------------------------------
// sew_pkg
// Shared widths, register indexes, FSM states and control/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sew_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 11;
  localparam int REG_IDX_W         = 2;
  localparam int DEFAULT_MAX_WIDTH = 1024;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FINAL_INVERT = 2'd2;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int MIN_DIM      = 2;
  localparam int HEIGHT_MAX   = 1024;

  localparam int ROW_W  = 11;  // row position, up to height + 1
  localparam int ROWX_W = 12;  // row position after a wrap, before restart check
  localparam int GRAD_W = 10;  // |Gx|, |Gy| <= 1020
  localparam int SQ_W   = 20;
  localparam int MAG_W  = 21;  // Gx^2 + Gy^2
  localparam int TT_W   = 16;  // trial root squared
  localparam int BIT_W  = 3;   // root bit index

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_GRAD,
    S_SQR,
    S_SUM,
    S_ROOT,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic accept;     // take input word, wrap / restart position
    logic decode;     // register window flags, read line buffer
    logic load;       // shift column in, write line buffer, advance
    logic grad;       // latch gradients from window
    logic sqr;        // square gradients
    logic sum;        // add squares, start root search
    logic root_step;  // one root bit
    logic push;       // load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic ignore;     // drain inside the frame
    logic case_a;     // result for the last pixel of the row two above the input
    logic case_b;     // result for the pixel above and left of the current one
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage

[design/sew_pix_if.sv]
// ----------------------------------------------------------------------------
// sew_pix_if
// Pixel input channel: valid/ready with pixel and drain payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sew_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sew_pkg::PIX_W-1:0] pixel;
  logic                      drain;

  modport source (output valid, output pixel, output drain, input ready);
  modport sink   (input valid, input pixel, input drain, output ready);
endinterface

[design/sew_wgt_if.sv]
// ----------------------------------------------------------------------------
// sew_wgt_if
// Edge-weight output channel: valid/ready with weight and frame-end flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sew_wgt_if;
  logic                      valid;
  logic                      ready;
  logic [sew_pkg::PIX_W-1:0] edge_weight;
  logic                      last_of_frame;

  modport source (output valid, output edge_weight, output last_of_frame, input ready);
  modport sink   (input valid, input edge_weight, input last_of_frame, output ready);
endinterface

[design/sew_ram.sv]
// ----------------------------------------------------------------------------
// sew_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sew_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sew_ctrl.sv]
// ----------------------------------------------------------------------------
// sew_ctrl
// Sequencer: one word at a time through decode, window, gradient, root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sew_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sew_pkg::dp_status_t   status,
  output sew_pkg::ctrl_cmd_t    cmd
);

  sew_pkg::state_t state;
  sew_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sew_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sew_pkg::S_IDLE: begin
        if (in_valid) state_next = sew_pkg::S_DECODE;
      end
      sew_pkg::S_DECODE: begin
        state_next = status.ignore ? sew_pkg::S_IDLE : sew_pkg::S_LOAD;
      end
      sew_pkg::S_LOAD: begin
        if (status.case_a)      state_next = sew_pkg::S_SQR;
        else if (status.case_b) state_next = sew_pkg::S_GRAD;
        else                    state_next = sew_pkg::S_IDLE;
      end
      sew_pkg::S_GRAD: state_next = sew_pkg::S_SQR;
      sew_pkg::S_SQR:  state_next = sew_pkg::S_SUM;
      sew_pkg::S_SUM:  state_next = sew_pkg::S_ROOT;
      sew_pkg::S_ROOT: begin
        if (status.root_last) state_next = sew_pkg::S_PUSH;
      end
      sew_pkg::S_PUSH: begin
        if (status.out_free) state_next = sew_pkg::S_IDLE;
      end
      default: state_next = sew_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      sew_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sew_pkg::S_DECODE: cmd.decode    = !status.ignore;
      sew_pkg::S_LOAD:   cmd.load      = 1'b1;
      sew_pkg::S_GRAD:   cmd.grad      = 1'b1;
      sew_pkg::S_SQR:    cmd.sqr       = 1'b1;
      sew_pkg::S_SUM:    cmd.sum       = 1'b1;
      sew_pkg::S_ROOT:   cmd.root_step = 1'b1;
      sew_pkg::S_PUSH:   cmd.push      = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/sew_dp.sv]
// ----------------------------------------------------------------------------
// sew_dp
// Datapath: config registers, position, line buffer, 3x3 window, gradient,
// squares, bit-serial root search and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sew_dp #(
  parameter int MAX_WIDTH = sew_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [sew_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [sew_pkg::CFG_W-1:0]       wr_data,
  input  logic [sew_pkg::PIX_W-1:0]       pixel,
  input  logic                            drain,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [sew_pkg::PIX_W-1:0]       edge_weight,
  output logic                            last_of_frame,
  input  sew_pkg::ctrl_cmd_t              cmd,
  output sew_pkg::dp_status_t             status
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = COL_W + 1;
  localparam int PW     = sew_pkg::PIX_W;
  localparam int CW     = sew_pkg::CFG_W;
  localparam int RW     = sew_pkg::ROW_W;
  localparam int RXW    = sew_pkg::ROWX_W;
  localparam int GW     = sew_pkg::GRAD_W;
  localparam int SW     = sew_pkg::SQ_W;
  localparam int MW     = sew_pkg::MAG_W;
  localparam int TW     = sew_pkg::TT_W;
  localparam int BW     = sew_pkg::BIT_W;

  // configuration
  logic [CW-1:0] image_width;
  logic [CW-1:0] image_height;
  logic          final_invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CW'(sew_pkg::RESET_WIDTH);
      image_height <= CW'(sew_pkg::RESET_HEIGHT);
      final_invert <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        sew_pkg::REG_IMAGE_WIDTH:  image_width  <= wr_data;
        sew_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data;
        sew_pkg::REG_FINAL_INVERT: final_invert <= wr_data[0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WW-1:0] w;
  logic [RW-1:0] h;

  always_comb begin
    if (image_width < CW'(sew_pkg::MIN_DIM))        w = WW'(sew_pkg::MIN_DIM);
    else if (32'(image_width) > 32'(MAX_WIDTH))     w = WW'(MAX_WIDTH);
    else                                            w = WW'(image_width);
    if (image_height < CW'(sew_pkg::MIN_DIM))       h = RW'(sew_pkg::MIN_DIM);
    else if (image_height > CW'(sew_pkg::HEIGHT_MAX)) h = RW'(sew_pkg::HEIGHT_MAX);
    else                                            h = RW'(image_height);
  end

  // position of the next input pixel
  logic [COL_W-1:0] col;
  logic [RW-1:0]    row;
  logic [PW-1:0]    pix_r;
  logic             drain_r;

  // wrap and restart on accept (covers geometry changed between frames)
  logic             wrap;
  logic [RXW-1:0]   row_x;
  logic [RXW-1:0]   h_plus;
  logic [COL_W-1:0] col_w;
  logic             restart_in;

  assign wrap       = WW'(col) >= w;
  assign row_x      = wrap ? (RXW'(row) + RXW'(1)) : RXW'(row);
  assign col_w      = wrap ? '0 : col;
  assign h_plus     = RXW'(h) + RXW'(1);
  assign restart_in = (row_x > h_plus) || ((row_x == h_plus) && (col_w != '0));

  // decode of the registered position
  logic          in_frame;
  logic          col_zero;
  logic          is_a;
  logic          is_b;
  logic          do_shift;
  logic [RW-1:0] h_p1;

  assign h_p1     = h + RW'(1);
  assign in_frame = row < h;
  assign col_zero = (col == '0);
  assign is_a     = col_zero && (row >= RW'(2));
  assign do_shift = row <= h;
  assign is_b     = do_shift && !col_zero && (row != '0);

  // flags held from decode to push
  logic          flag_a;
  logic          flag_b;
  logic          flag_shift;
  logic          flag_last;
  logic          m_top;
  logic          m_bot;
  logic          m_left;
  logic          m_right;
  logic [PW-1:0] pix_eff;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r   <= pixel;
      drain_r <= drain;
    end
    if (cmd.decode) begin
      flag_a     <= is_a;
      flag_b     <= is_b;
      flag_shift <= do_shift;
      flag_last  <= is_a && (row == h_p1);
      pix_eff    <= in_frame ? pix_r : '0;
      if (is_a) begin
        // last pixel of the row two above the current input row
        m_top   <= (row == RW'(2));
        m_bot   <= (row > h);
        m_left  <= 1'b0;
        m_right <= 1'b1;
      end else begin
        m_top   <= (row == RW'(1));
        m_bot   <= (row >= h);
        m_left  <= (col == COL_W'(1));
        m_right <= 1'b0;
      end
    end
  end

  // advance
  logic [WW-1:0] col_inc;
  assign col_inc = WW'(col) + WW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      if (restart_in) begin
        col <= '0;
        row <= '0;
      end else begin
        col <= col_w;
        row <= RW'(row_x);
      end
    end else if (cmd.load) begin
      if (flag_a && flag_last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= w) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

  // line buffer: {row above, current row} per column
  logic [2*PW-1:0] lb_rdata;
  logic [PW-1:0]   lb_top;
  logic [PW-1:0]   lb_mid;

  assign lb_top = lb_rdata[2*PW-1:PW];
  assign lb_mid = lb_rdata[PW-1:0];

  sew_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.load && flag_shift),
    .waddr (col),
    .wdata ({lb_mid, pix_eff}),
    .re    (cmd.decode),
    .raddr (col),
    .rdata (lb_rdata)
  );

  // 3x3 window, win[column old..new][row top..bottom]
  logic [PW-1:0] win [3][3];
  logic [PW-1:0] new_col [3];

  assign new_col[0] = lb_top;
  assign new_col[1] = lb_mid;
  assign new_col[2] = pix_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else if ((cmd.accept && restart_in) || (cmd.load && flag_a && flag_last)) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else if (cmd.decode && col_zero) begin
      // row start: blank column in before the row's first pixel
      for (int r = 0; r < 3; r++) begin
        win[0][r] <= win[1][r];
        win[1][r] <= win[2][r];
        win[2][r] <= '0;
      end
    end else if (cmd.load && flag_shift) begin
      for (int r = 0; r < 3; r++) begin
        win[0][r] <= win[1][r];
        win[1][r] <= win[2][r];
        win[2][r] <= new_col[r];
      end
    end
  end

  // gradients with border masking
  logic [PW-1:0] p [3][3];  // [row][col]
  logic [GW-1:0] s_left;
  logic [GW-1:0] s_right;
  logic [GW-1:0] s_top;
  logic [GW-1:0] s_bot;
  logic [GW-1:0] ax;
  logic [GW-1:0] ay;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && m_top) || (r == 2 && m_bot) ||
            (c == 0 && m_left) || (c == 2 && m_right)) begin
          p[r][c] = '0;
        end else begin
          p[r][c] = win[c][r];
        end
      end
    end
  end

  assign s_right = GW'(p[0][2]) + (GW'(p[1][2]) << 1) + GW'(p[2][2]);
  assign s_left  = GW'(p[0][0]) + (GW'(p[1][0]) << 1) + GW'(p[2][0]);
  assign s_bot   = GW'(p[2][0]) + (GW'(p[2][1]) << 1) + GW'(p[2][2]);
  assign s_top   = GW'(p[0][0]) + (GW'(p[0][1]) << 1) + GW'(p[0][2]);
  assign ax      = (s_right >= s_left) ? (s_right - s_left) : (s_left - s_right);
  assign ay      = (s_bot >= s_top) ? (s_bot - s_top) : (s_top - s_bot);

  // squares, sum, root search
  logic [GW-1:0] ax_r;
  logic [GW-1:0] ay_r;
  logic [SW-1:0] sqx;
  logic [SW-1:0] sqy;
  logic [MW-1:0] mag;
  logic [PW-1:0] root;
  logic [BW-1:0] bit_idx;
  logic [PW-1:0] trial;
  logic [TW-1:0] trial_sq;
  logic [MW-1:0] trial_x20;

  // r^2 <= floor(v/20) exactly when 20*r^2 <= v, so no divider is needed;
  // an 8-bit search also saturates at 255 by itself
  assign trial     = root | (PW'(1) << bit_idx);
  assign trial_sq  = TW'(trial) * TW'(trial);
  assign trial_x20 = (MW'(trial_sq) << 4) + (MW'(trial_sq) << 2);

  always_ff @(posedge clk) begin
    if ((cmd.load && flag_a) || cmd.grad) begin
      ax_r <= ax;
      ay_r <= ay;
    end
    if (cmd.sqr) begin
      sqx <= SW'(ax_r) * SW'(ax_r);
      sqy <= SW'(ay_r) * SW'(ay_r);
    end
    if (cmd.sum) begin
      mag     <= MW'(sqx) + MW'(sqy);
      root    <= '0;
      bit_idx <= BW'(PW - 1);
    end else if (cmd.root_step) begin
      if (trial_x20 <= mag) root <= trial;
      bit_idx <= bit_idx - BW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      edge_weight   <= ~root ^ {PW{final_invert}};
      last_of_frame <= flag_last;
    end
  end

  assign status.ignore    = in_frame && drain_r;
  assign status.case_a    = flag_a;
  assign status.case_b    = flag_b;
  assign status.root_last = (bit_idx == '0);
  assign status.out_free  = !out_valid || out_ready;

endmodule

[design/sobel_edge_weight_3x3.sv]
// Words are taken one at a time; the input is closed until a word is done:
// an ignored drain after decode, a word with no result after load, and a
// producing word after the 8-step root search and the output load (a row-end
// result skips the grad state). The root search uses a single squarer.
// Reset (synchronous, rst high): idle, frame position and window zeroed,
// registers back to 640 x 480, no inversion; line buffer contents undefined.
// ----------------------------------------------------------------------------
// sobel_edge_weight_3x3
// Streaming 3x3 Sobel edge weight for 8-bit gray frames in raster order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Data flow per input word:
//   accept  - word captured; a column past the row end wraps, a position past
//             the frame end restarts the frame (window cleared).
//   decode  - border and result flags registered, line buffer read at the
//             column; at a row start a blank column enters the window.
//   load    - new column {two rows up, row above, pixel} shifted in, line buffer
//             written; for a row-end result the gradients are taken here,
//             before the shift.
//   grad    - gradients for an interior result.
//   sqr/sum - Gx^2, Gy^2 and their sum.
//   root    - one bit per step, from the top bit down: largest r with 20*r^2 <= sum.
//   push    - ~r, optionally inverted again, into the output register.
// The output register holds its word while the sink stalls; the next input
// word is taken as soon as the result is loaded.
// Results trail the input by one row plus one pixel; width+1 drain words
// after the frame flush the last row, the final one flagged last_of_frame.

module sobel_edge_weight_3x3 #(
  parameter int MAX_WIDTH = sew_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // register writes
  input  logic                          wr_en,
  input  logic [sew_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [sew_pkg::CFG_W-1:0]     wr_data,
  // streams
  sew_pix_if.sink                       pixels,
  sew_wgt_if.source                     weights
);

  // command / status bundle between sequencer and datapath
  sew_pkg::ctrl_cmd_t  cmd;
  sew_pkg::dp_status_t status;

  sew_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sew_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .pixel         (pixels.pixel),
    .drain         (pixels.drain),
    .out_ready     (weights.ready),
    .out_valid     (weights.valid),
    .edge_weight   (weights.edge_weight),
    .last_of_frame (weights.last_of_frame),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

[design/sew_checker.sv]
// ----------------------------------------------------------------------------
// sew_checker
// Port-level checks on the Sobel edge-weight block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_edge_weight_3x3_defines.svh"

module sew_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sew_pkg::PIX_W-1:0] edge_weight,
  input logic                      last_of_frame
);

  // whole output word, for the hold check
  logic [sew_pkg::PIX_W:0] out_word;
  assign out_word = {last_of_frame, edge_weight};

  // one word in flight: input closes right after a word is taken
  `SEW_ASSERT_NEXT(a_one_word_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a new result is only loaded while the input side is closed
  `SEW_ASSERT_SAME(a_result_while_busy, clk, rst, $rose(out_valid), !$past(in_ready))

  `SEW_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid)

  `SEW_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_word))

endmodule

bind sobel_edge_weight_3x3 sew_checker u_sew_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixels.valid),
  .in_ready      (pixels.ready),
  .out_valid     (weights.valid),
  .out_ready     (weights.ready),
  .edge_weight   (weights.edge_weight),
  .last_of_frame (weights.last_of_frame)
);
